// File: hw/rtl/hsrd_pkg.sv
// ----------------------------------------------------------------------------
// hsrd_pkg
// Shared widths, constants and helper functions for the humidity sensor
// reply decoder: CRC-8 byte update and the divide-by-65535 step.
// ----------------------------------------------------------------------------
package hsrd_pkg;

  // field widths
  localparam int RxW   = 8;
  localparam int TempW = 15;
  localparam int HumW  = 14;
  localparam int OutW  = 32;

  // crc-8 setup
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // conversion constants, in hundredths
  localparam logic [14:0] TempSpan   = 15'd17500;
  localparam logic [14:0] TempOffset = 15'd4500;
  localparam logic [13:0] HumSpan    = 14'd12500;
  localparam logic [15:0] HumOffset  = 16'd600;
  localparam logic [13:0] HumMax     = 14'd10000;
  // quotient above which humidity saturates high
  localparam logic [15:0] HumQuotMax = 16'd10600;

  // one byte through the crc-8, msb first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // floor(x / 65535) for quotients below 65536, as an add and a shift
  function automatic logic [15:0] div_full_scale(input logic [31:0] x);
    logic [31:0] s;
    s = x + {16'd0, x[31:16]} + 32'd1;
    return s[31:16];
  endfunction

endpackage

// File: hw/rtl/humidity_sensor_reply_decoder_core.sv
// ----------------------------------------------------------------------------
// humidity_sensor_reply_decoder_core
// Decodes the six-byte measurement reply (two words, each with a CRC-8
// byte) into temperature and humidity in hundredths, with CRC flags.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, back to back, while the result register
//   is free or being emptied in the same cycle.
// Result: valid in the cycle after the sixth byte is accepted;
//   word products are registered when each word's low byte arrives.
// Reset (rst, synchronous): byte position to the first byte, CRC to 0xFF,
//   CRC flag and result valid cleared.
module humidity_sensor_reply_decoder_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [hsrd_pkg::RxW-1:0]     s_tdata,  // [7:0] rx_byte
  input  logic                         s_tuser,  // [0] first_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [hsrd_pkg::OutW-1:0]    m_tdata   // [14:0] temperature_centi,
                                                 // [28:15] humidity_centi,
                                                 // [29] temp_crc_ok,
                                                 // [30] hum_crc_ok,
                                                 // [31] hum_clamped
);
  import hsrd_pkg::*;

  typedef enum logic [2:0] {
    POS_T_MSB,
    POS_T_LSB,
    POS_T_CRC,
    POS_H_MSB,
    POS_H_LSB,
    POS_H_CRC
  } pos_t;

  // frame state
  pos_t        pos;
  pos_t        pos_next;
  logic [7:0]  crc;
  logic [7:0]  crc_next;
  logic [7:0]  high_byte;
  logic        temp_flag;
  logic        temp_flag_next;
  logic [30:0] temp_prod;
  logic [29:0] hum_prod;

  // result register
  logic [TempW-1:0] temp_out;
  logic [HumW-1:0]  hum_out;
  logic             temp_ok_out;
  logic             hum_ok_out;
  logic             clamp_out;

  // datapath
  logic        accept;
  logic        out_load;
  logic        load_temp;
  logic        load_hum;
  pos_t        pos_cur;
  logic [15:0] word;
  logic [7:0]  crc_fed;
  logic [15:0] temp_quot;
  logic [15:0] hum_quot;
  logic [TempW-1:0] temp_val;
  logic [HumW-1:0]  hum_val;
  logic             hum_clamp;
  logic             hum_ok;

  // input side free unless a result is stuck in the output register
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // byte position, crc and word assembly
  always_comb begin
    pos_cur        = s_tuser ? POS_T_MSB : pos;
    word           = {high_byte, s_tdata};
    crc_fed        = crc8_feed(crc, s_tdata);
    pos_next       = pos_cur;
    crc_next       = crc;
    temp_flag_next = temp_flag;
    load_temp      = 1'b0;
    load_hum       = 1'b0;
    out_load       = 1'b0;
    unique case (pos_cur) inside
      POS_T_MSB, POS_H_MSB: begin
        crc_next = crc8_feed(CrcInit, s_tdata);
        pos_next = (pos_cur == POS_T_MSB) ? POS_T_LSB : POS_H_LSB;
      end
      POS_T_LSB: begin
        crc_next  = crc_fed;
        load_temp = 1'b1;
        pos_next  = POS_T_CRC;
      end
      POS_T_CRC: begin
        temp_flag_next = (crc == s_tdata);
        crc_next       = CrcInit;
        pos_next       = POS_H_MSB;
      end
      POS_H_LSB: begin
        crc_next = crc_fed;
        load_hum = 1'b1;
        pos_next = POS_H_CRC;
      end
      POS_H_CRC: begin
        crc_next = CrcInit;
        out_load = 1'b1;
        pos_next = POS_T_MSB;
      end
      default: begin
        // out-of-range position restarts as a first byte
        crc_next = crc8_feed(CrcInit, s_tdata);
        pos_next = POS_T_LSB;
      end
    endcase
  end

  // conversion from the registered word products
  always_comb begin
    temp_quot = div_full_scale({1'b0, temp_prod});
    hum_quot  = div_full_scale({2'b0, hum_prod});
    temp_val  = temp_quot[TempW-1:0] - TempOffset;
    hum_ok    = (crc == s_tdata);
    if (hum_quot < HumOffset) begin
      hum_val   = '0;
      hum_clamp = 1'b1;
    end else if (hum_quot > HumQuotMax) begin
      hum_val   = HumMax;
      hum_clamp = 1'b1;
    end else begin
      hum_val   = hum_quot[HumW-1:0] - HumOffset[HumW-1:0];
      hum_clamp = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_T_MSB;
      crc       <= CrcInit;
      temp_flag <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (accept) begin
        pos       <= pos_next;
        crc       <= crc_next;
        temp_flag <= temp_flag_next;
      end
      if (accept && out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (accept) begin
      high_byte <= s_tdata;
    end
    if (accept && load_temp) begin
      temp_prod <= {15'd0, word} * {16'd0, TempSpan};
    end
    if (accept && load_hum) begin
      hum_prod <= {14'd0, word} * {16'd0, HumSpan};
    end
    if (accept && out_load) begin
      temp_out    <= temp_val;
      hum_out     <= hum_val;
      temp_ok_out <= temp_flag;
      hum_ok_out  <= hum_ok;
      clamp_out   <= hum_clamp;
    end
  end

  assign m_tdata = {clamp_out, hum_ok_out, temp_ok_out, hum_out, temp_out};

  // a new result only follows an accepted byte
  a_result_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result appeared without an accepted byte");

  // humidity stays within its saturated range
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[28:15] <= HumMax))
    else $error("humidity above full scale");

  // clamp flag only with a saturated value
  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[31]) |-> (m_tdata[28:15] == '0 || m_tdata[28:15] == HumMax))
    else $error("clamp flag with an unsaturated humidity");

  // byte position never leaves the six-byte frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_H_CRC)
    else $error("byte position out of range");

endmodule

// File: tb/humidity_sensor_reply_decoder_checker.sv
// ----------------------------------------------------------------------------
// humidity_sensor_reply_decoder_checker
// Watches the request and result streams of the reply decoder, tracks the
// reply framing and CRC-8 on its own, converts each completed reply to
// temperature and humidity in hundredths and compares every result field.
// ----------------------------------------------------------------------------
module humidity_sensor_reply_decoder_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [hsrd_pkg::RxW-1:0]  s_tdata,   // [7:0] rx_byte
  input  logic                      s_tuser,   // [0] first_byte
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [hsrd_pkg::OutW-1:0] m_tdata,   // [14:0] temperature_centi,
                                               // [28:15] humidity_centi,
                                               // [29] temp_crc_ok,
                                               // [30] hum_crc_ok,
                                               // [31] hum_clamped
  output int                        errors,
  output int                        pending,
  output int                        readings
);
  timeunit 1ns;
  timeprecision 1ps;

  // positions within the six-byte reply
  localparam logic [2:0] PosTempMsb = 3'd0;
  localparam logic [2:0] PosTempLsb = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumMsb  = 3'd3;
  localparam logic [2:0] PosHumLsb  = 3'd4;
  localparam logic [2:0] PosHumCrc  = 3'd5;

  localparam logic [7:0] Poly      = 8'h31;
  localparam logic [7:0] Seed      = 8'hFF;
  localparam longint     FullScale = 65535;
  localparam longint     TempScale = 17500;
  localparam int         TempBase  = -4500;
  localparam longint     HumScale  = 12500;
  localparam int         HumBase   = -600;
  localparam int         HumTop    = 10000;

  // one result, laid out as on m_tdata
  typedef struct packed {
    logic               clamp;
    logic               hum_ok;
    logic               temp_ok;
    logic [13:0]        hum;
    logic signed [14:0] temp;
  } reading_t;

  reading_t expected_readings[$];
  reading_t got, want;

  logic [2:0]  frame_pos;
  logic [7:0]  word_crc;
  logic [7:0]  msb_hold;
  logic [15:0] temp_word;
  logic [15:0] hum_word;
  logic        temp_crc_good;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    repeat (8) begin
      if (c[7]) c = (c << 1) ^ Poly;
      else c = c << 1;
    end
    return c;
  endfunction

  // advance the reply framing by one request byte
  task automatic decode_req(input logic [7:0] data, input logic marker);
    reading_t r;
    int t_val;
    int h_val;
    if (marker || frame_pos > PosHumCrc) frame_pos = PosTempMsb;
    case (frame_pos)
      PosTempMsb, PosHumMsb: begin
        word_crc = crc8_step(Seed, data);
        msb_hold = data;
        frame_pos = frame_pos + 3'd1;
      end
      PosTempLsb: begin
        temp_word = {msb_hold, data};
        word_crc = crc8_step(word_crc, data);
        frame_pos = PosTempCrc;
      end
      PosHumLsb: begin
        hum_word = {msb_hold, data};
        word_crc = crc8_step(word_crc, data);
        frame_pos = PosHumCrc;
      end
      PosTempCrc: begin
        temp_crc_good = (word_crc == data);
        word_crc = Seed;
        frame_pos = PosHumMsb;
      end
      default: begin
        // last byte: humidity crc and the conversion of both words
        t_val = TempBase + int'((longint'(temp_word) * TempScale) / FullScale);
        h_val = HumBase + int'((longint'(hum_word) * HumScale) / FullScale);
        r.clamp = 1'b0;
        if (h_val < 0) begin
          h_val = 0;
          r.clamp = 1'b1;
        end else if (h_val > HumTop) begin
          h_val = HumTop;
          r.clamp = 1'b1;
        end
        r.temp = 15'(t_val);
        r.hum = 14'(h_val);
        r.temp_ok = temp_crc_good;
        r.hum_ok = (word_crc == data);
        expected_readings.push_back(r);
        word_crc = Seed;
        frame_pos = PosTempMsb;
      end
    endcase
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  // results first: one taken in this cycle was caused by an earlier request
  always @(posedge clk) begin
    if (rst) begin
      frame_pos = PosTempMsb;
      word_crc = Seed;
      msb_hold = '0;
      temp_word = '0;
      hum_word = '0;
      temp_crc_good = 1'b0;
      expected_readings.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_readings.size() == 0) begin
          $error("result 0x%08h with no reading expected", m_tdata);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          check_field("temperature_centi", int'($signed(want.temp)),
                      int'($signed(got.temp)));
          check_field("humidity_centi", int'(want.hum), int'(got.hum));
          check_field("temp_crc_ok", int'(want.temp_ok), int'(got.temp_ok));
          check_field("hum_crc_ok", int'(want.hum_ok), int'(got.hum_ok));
          check_field("hum_clamped", int'(want.clamp), int'(got.clamp));
          readings++;
        end
      end
      if (s_tvalid && s_tready) decode_req(s_tdata, s_tuser);
    end
    pending = expected_readings.size();
  end

endmodule

// File: tb/humidity_sensor_reply_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// humidity_sensor_reply_decoder_core_tb
// Feeds the reply decoder with directed and random six-byte replies (good,
// CRC-faulted, cut short, resynchronized by the marker, plain noise) under
// random idling on both streams; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module humidity_sensor_reply_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SendTarget = 450;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [hsrd_pkg::RxW-1:0]  s_tdata = '0;
  logic                      s_tuser = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [hsrd_pkg::OutW-1:0] m_tdata;

  int errors;
  int pending;
  int readings;
  int bytes_sent = 0;
  int replies_full = 0;
  int replies_faulted = 0;
  int replies_cut = 0;
  int noise_bursts = 0;
  int s_mode = 0;
  int m_mode = 0;
  int stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  humidity_sensor_reply_decoder_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  humidity_sensor_reply_decoder_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending),
    .readings (readings)
  );

  // idle length: mode 0 none, 1 short only, 2 mostly short with a few long
  function automatic int pick_gap(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85 || mode == 1) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // raw words: corners and values around the humidity clamp points
  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h8000;
          default: return 16'h7FFF;
        endcase
      end
      1: return 16'(($urandom_range(0, 1) ? 3146 : 55578) + $urandom_range(0, 6) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  // result side stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (m_mode != 0 && $urandom_range(0, 2) == 0) begin
      m_tready <= 1'b0;
      stall_left <= pick_gap(m_mode);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // one request byte; returns at the falling edge after it was taken
  task automatic send_req(input logic [7:0] data, input logic marker);
    int gap;
    gap = pick_gap(s_mode);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tuser <= marker;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // first count bytes of a reply; corrupt[0] spoils the temperature crc,
  // corrupt[1] the humidity crc
  task automatic send_reply(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input logic marker, input logic [1:0] corrupt,
                            input int count);
    logic [7:0] frame [6];
    frame[0] = t_raw[15:8];
    frame[1] = t_raw[7:0];
    frame[2] = hsrd_pkg::crc8_feed(hsrd_pkg::crc8_feed(hsrd_pkg::CrcInit, frame[0]), frame[1]);
    frame[3] = h_raw[15:8];
    frame[4] = h_raw[7:0];
    frame[5] = hsrd_pkg::crc8_feed(hsrd_pkg::crc8_feed(hsrd_pkg::CrcInit, frame[3]), frame[4]);
    if (corrupt[0]) frame[2] = frame[2] ^ (8'h01 << $urandom_range(0, 7));
    if (corrupt[1]) frame[5] = frame[5] ^ (8'h01 << $urandom_range(0, 7));
    for (int k = 0; k < count; k++) send_req(frame[k], (k == 0) ? marker : 1'b0);
    if (count == 6) replies_full++;
    else replies_cut++;
    if (corrupt != 2'b00) replies_faulted++;
  endtask

  // hold the sender until every outstanding reading has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    int kind;
    int step;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: corners, both clamp directions, crc faults, marker handling
    send_reply(16'h0000, 16'h0000, 1'b1, 2'b00, 6);
    send_reply(16'hFFFF, 16'hFFFF, 1'b0, 2'b00, 6);
    send_reply(16'h8000, 16'd3146, 1'b1, 2'b01, 6);
    send_reply(16'h1234, 16'h5678, 1'b1, 2'b00, 2);
    send_reply(16'h7FFF, 16'd55578, 1'b1, 2'b10, 6);
    drain();

    // random: mostly well-formed replies, some faulted, cut or noise
    step = 0;
    while (bytes_sent < SendTarget) begin
      if (step % 10 == 0) begin
        s_mode = $urandom_range(0, 2);
        m_mode = $urandom_range(0, 2);
      end
      if (step == 30) drain();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_reply(pick_raw(), pick_raw(), $urandom_range(0, 4) != 0, 2'b00, 6);
      end else if (kind < 80) begin
        send_reply(pick_raw(), pick_raw(), $urandom_range(0, 4) != 0,
                   2'($urandom_range(1, 3)), 6);
      end else if (kind < 90) begin
        send_reply(pick_raw(), pick_raw(), 1'b1, 2'b00, $urandom_range(1, 5));
      end else begin
        repeat ($urandom_range(1, 4)) send_req(8'($urandom), 1'($urandom_range(0, 1)));
        noise_bursts++;
      end
      step++;
    end
    s_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (8) @(negedge clk);
    $display("sent %0d request bytes: %0d full replies, %0d cut short, %0d crc-faulted,",
             bytes_sent, replies_full, replies_cut, replies_faulted);
    $display("%0d noise bursts; %0d readings checked", noise_bursts, readings);
    if (pending != 0) $error("%0d readings never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("humidity_sensor_reply_decoder_core regression: pass");
    end else begin
      $display("humidity_sensor_reply_decoder_core regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("humidity_sensor_reply_decoder_core regression: fail");
    $finish;
  end

endmodule
